// File: rtl/bma_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, codes and state types of the buddy allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

   localparam int MaxLevelsDefault  = 10;
   localparam int OffsetBitsDefault = 26;
   localparam int ReqBits           = 26;

   localparam logic [4:0] MinLog2Reset = 5'd7;
   localparam logic [3:0] LevelsReset  = 4'd10;
   localparam logic [6:0] HeaderReset  = 7'd16;

   typedef enum logic [1:0] {
      CSR_MIN_LOG2 = 2'd0,
      CSR_LEVELS   = 2'd1,
      CSR_HEADER   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_BLOCK = 2'd1,
      ST_TOO_BIG  = 2'd2,
      ST_BAD_FREE = 2'd3
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_A_SIZE,
      S_A_SCAN,
      S_A_CHECK,
      S_A_SPLIT,
      S_A_DONE,
      S_F_CHECK,
      S_F_MARK,
      S_F_READ,
      S_F_MERGE,
      S_RESULT
   } state_type;

endpackage

// File: rtl/bma_if.sv
// ----------------------------------------------------------------------------
// Buddy allocator channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface bma_req_if #(
   parameter int OffsetBits = bma_pkg::OffsetBitsDefault
);
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [bma_pkg::ReqBits-1:0]  request_bytes;
   logic [OffsetBits-1:0]        payload_offset;

   modport source (output valid, op, request_bytes, payload_offset, input ready);
   modport sink   (input valid, op, request_bytes, payload_offset, output ready);
endinterface

interface bma_rsp_if #(
   parameter int OffsetBits = bma_pkg::OffsetBitsDefault
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [OffsetBits-1:0] granted_offset;
   logic [3:0]            granted_order;
   logic                  merged;

   modport source (output valid, status, granted_offset, granted_order, merged,
                   input ready);
   modport sink   (input valid, status, granted_offset, granted_order, merged,
                   output ready);
endinterface

// File: rtl/buddy_memory_allocator.sv
// ----------------------------------------------------------------------------
// Buddy memory allocator
// Binary buddy allocator with its free tree, order store and allocation marks
// held in synchronous memories.
// ----------------------------------------------------------------------------
// One item is worked at a time. After reset and after every configuration
// write made outside the result state, a clearing pass resets the free tree
// and the allocation marks; no request beat is taken during it. An alloc
// sizes the request order by order, searches the tree node by node (up to
// 2^(levels+1)-1 nodes) and splits the found block level by level. A free
// checks the offset and the allocation mark, marks its node free and reads
// its buddy, merging level by level while the buddy is free; a rejected
// free ends after the offset or the mark check. An item that finishes while
// the previous response still waits holds until that beat is taken. The
// free tree memory has a single read port. The response sits in an output
// register, so a response that waits does not lose state.
module buddy_memory_allocator #(
   parameter int MaxLevels  = bma_pkg::MaxLevelsDefault,
   parameter int OffsetBits = bma_pkg::OffsetBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data,
   bma_req_if.sink    req,
   bma_rsp_if.source  rsp
);
   localparam int TreeSlots = 2 << MaxLevels;
   localparam int LeafSlots = 1 << MaxLevels;
   localparam int TB = MaxLevels + 1;
   localparam int LB = (MaxLevels > 0) ? MaxLevels : 1;
   localparam int WB = OffsetBits + 2;

   logic tree_mem [TreeSlots];
   logic mark_mem [LeafSlots];
   logic [3:0] ord_mem [LeafSlots];

   bma_pkg::state_type state_ff, state_in;
   logic [4:0] m_ff;
   logic [3:0] lv_ff;
   logic [6:0] hdr_ff;

   logic [TB-1:0] clr_ff, clr_in;
   logic [3:0] k_ff, k_in;
   logic [4:0] d_ff, d_in;
   logic [4:0] lvl_ff, lvl_in;
   logic [MaxLevels:0] pos_ff, pos_in;
   logic [LB-1:0] b_ff, b_in;
   logic mg_ff, mg_in;
   logic [WB-1:0] need_ff, need_in;
   logic [1:0] st_ff, st_in;
   logic [OffsetBits-1:0] goff_ff, goff_in;
   logic rvalid_ff, rvalid_in;

   logic tree_rd_en;
   logic [TB-1:0] tree_rd_addr;
   logic tree_q_ff;
   logic tree_we;
   logic [TB-1:0] tree_wa;
   logic tree_wd;
   logic tree_we2;
   logic [TB-1:0] tree_wa2;
   logic mark_q_ff;
   logic [3:0] ord_q_ff;
   logic mark_we, mark_wd, ord_we;

   logic acc;
   logic [WB-1:0] blk_sz;
   logic [WB-1:0] off_w;

   function automatic logic [TB-1:0] slot(input logic [4:0] d,
                                          input logic [MaxLevels:0] p);
      logic [TB:0] s;
      s = (TB+1)'(1) << d;
      s = s + (TB+1)'(p);
      return s[TB-1:0];
   endfunction

   assign acc = req.valid && req.ready;
   assign req.ready = (state_ff == bma_pkg::S_IDLE) && !csr_write;
   assign blk_sz = WB'(1) << (m_ff + 5'(k_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff <= bma_pkg::MinLog2Reset;
         lv_ff <= (MaxLevels < 10) ? 4'(MaxLevels) : bma_pkg::LevelsReset;
         hdr_ff <= bma_pkg::HeaderReset;
      end else if (csr_write) begin
         case (csr_index)
            bma_pkg::CSR_MIN_LOG2: begin
               m_ff <= (csr_data[4:0] < 5'd3) ? 5'd3 :
                       (csr_data[4:0] > 5'd16) ? 5'd16 : csr_data[4:0];
            end
            bma_pkg::CSR_LEVELS: begin
               lv_ff <= (csr_data[3:0] > 4'(MaxLevels)) ? 4'(MaxLevels) : csr_data[3:0];
            end
            bma_pkg::CSR_HEADER: begin
               hdr_ff <= (csr_data > 7'd64) ? 7'd64 : csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (tree_rd_en) tree_q_ff <= tree_mem[tree_rd_addr];
      if (tree_we) tree_mem[tree_wa] <= tree_wd;
      if (tree_we2) tree_mem[tree_wa2] <= 1'b0;
      mark_q_ff <= mark_mem[b_in];
      ord_q_ff <= ord_mem[b_in];
      if (mark_we) mark_mem[b_ff] <= mark_wd;
      if (ord_we) ord_mem[b_ff] <= k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bma_pkg::S_CLEAR;
         clr_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rvalid_ff <= rvalid_in;
      end
      k_ff <= k_in;
      d_ff <= d_in;
      lvl_ff <= lvl_in;
      pos_ff <= pos_in;
      b_ff <= b_in;
      mg_ff <= mg_in;
      need_ff <= need_in;
      st_ff <= st_in;
      goff_ff <= goff_in;
   end

   always_comb begin
      state_in = state_ff;
      if (csr_write && state_ff != bma_pkg::S_RESULT) begin
         state_in = bma_pkg::S_CLEAR;
      end else begin
         case (state_ff)
            bma_pkg::S_CLEAR:
               if (clr_ff == TB'(TreeSlots - 1)) state_in = bma_pkg::S_IDLE;
            bma_pkg::S_IDLE:
               if (acc) state_in = (req.op == bma_pkg::OP_ALLOC) ?
                                   bma_pkg::S_A_SIZE : bma_pkg::S_F_CHECK;
            bma_pkg::S_A_SIZE:
               if (blk_sz >= need_ff) state_in = bma_pkg::S_A_SCAN;
               else if (k_ff >= lv_ff) state_in = bma_pkg::S_RESULT;
            bma_pkg::S_A_SCAN: state_in = bma_pkg::S_A_CHECK;
            bma_pkg::S_A_CHECK:
               if (tree_q_ff) state_in = bma_pkg::S_A_SPLIT;
               else if (pos_ff == (MaxLevels+1)'((1 << lvl_ff) - 1) && lvl_ff == 5'd0)
                  state_in = bma_pkg::S_RESULT;
               else state_in = bma_pkg::S_A_SCAN;
            bma_pkg::S_A_SPLIT:
               if (lvl_ff >= d_ff) state_in = bma_pkg::S_A_DONE;
            bma_pkg::S_A_DONE: state_in = bma_pkg::S_RESULT;
            bma_pkg::S_F_CHECK:
               state_in = (st_ff == bma_pkg::ST_BAD_FREE) ? bma_pkg::S_RESULT :
                          bma_pkg::S_F_MARK;
            bma_pkg::S_F_MARK:
               state_in = mark_q_ff ? bma_pkg::S_F_READ : bma_pkg::S_RESULT;
            bma_pkg::S_F_READ:
               state_in = (d_ff == 5'd0) ? bma_pkg::S_RESULT : bma_pkg::S_F_MERGE;
            bma_pkg::S_F_MERGE:
               state_in = tree_q_ff ? bma_pkg::S_F_READ : bma_pkg::S_RESULT;
            bma_pkg::S_RESULT:
               if (!rvalid_ff || rsp.ready) state_in = bma_pkg::S_IDLE;
            default: state_in = bma_pkg::S_CLEAR;
         endcase
      end
   end

   always_comb begin
      clr_in = (state_ff == bma_pkg::S_CLEAR) ? clr_ff + TB'(1) : '0;
      k_in = k_ff;
      d_in = d_ff;
      lvl_in = lvl_ff;
      pos_in = pos_ff;
      b_in = b_ff;
      mg_in = mg_ff;
      need_in = need_ff;
      st_in = st_ff;
      goff_in = goff_ff;
      rvalid_in = rvalid_ff;
      tree_rd_en = 1'b0;
      tree_rd_addr = slot(lvl_ff, pos_ff);
      tree_we = 1'b0;
      tree_wa = slot(lvl_ff, pos_ff);
      tree_wd = 1'b0;
      tree_we2 = 1'b0;
      tree_wa2 = slot(lvl_ff, pos_ff ^ (MaxLevels+1)'(1));
      mark_we = 1'b0;
      mark_wd = 1'b0;
      ord_we = 1'b0;
      off_w = '0;
      if (rsp.ready) rvalid_in = 1'b0;
      case (state_ff)
         bma_pkg::S_CLEAR: begin
            tree_we = 1'b1;
            tree_wa = clr_ff;
            tree_wd = (clr_ff == TB'(1));
            b_in = clr_ff[LB-1:0];
            mark_we = (clr_ff <= TB'(LeafSlots));
            mark_wd = 1'b0;
         end
         bma_pkg::S_IDLE: begin
            need_in = WB'(req.request_bytes) + WB'(hdr_ff);
            k_in = '0;
            mg_in = 1'b0;
            st_in = bma_pkg::ST_OK;
            goff_in = '0;
            off_w = WB'(req.payload_offset) - WB'(hdr_ff);
            if (req.op == bma_pkg::OP_FREE &&
                (WB'(req.payload_offset) < WB'(hdr_ff) ||
                 (off_w >> (m_ff + 5'(lv_ff))) != '0 ||
                 (off_w & ((WB'(1) << m_ff) - WB'(1))) != '0))
               st_in = bma_pkg::ST_BAD_FREE;
            b_in = LB'(off_w >> m_ff);
         end
         bma_pkg::S_A_SIZE: begin
            if (blk_sz >= need_ff) begin
               d_in = 5'(lv_ff - k_ff);
               lvl_in = 5'(lv_ff - k_ff);
               pos_in = '0;
            end else if (k_ff >= lv_ff) begin
               st_in = bma_pkg::ST_TOO_BIG;
            end else begin
               k_in = k_ff + 4'd1;
            end
         end
         bma_pkg::S_A_SCAN: begin
            tree_rd_en = 1'b1;
         end
         bma_pkg::S_A_CHECK: begin
            if (tree_q_ff) begin
               tree_we = 1'b1;
            end else if (pos_ff == (MaxLevels+1)'((1 << lvl_ff) - 1)) begin
               if (lvl_ff == 5'd0) st_in = bma_pkg::ST_NO_BLOCK;
               else begin
                  lvl_in = lvl_ff - 5'd1;
                  pos_in = '0;
               end
            end else begin
               pos_in = pos_ff + (MaxLevels+1)'(1);
            end
         end
         bma_pkg::S_A_SPLIT: begin
            if (lvl_ff < d_ff) begin
               lvl_in = lvl_ff + 5'd1;
               pos_in = pos_ff << 1;
               tree_we = 1'b1;
               tree_wa = slot(lvl_ff + 5'd1, (pos_ff << 1) | (MaxLevels+1)'(1));
               tree_wd = 1'b1;
            end else begin
               b_in = LB'(pos_ff << k_ff);
            end
         end
         bma_pkg::S_A_DONE: begin
            mark_we = 1'b1;
            mark_wd = 1'b1;
            ord_we = 1'b1;
            off_w = (WB'(b_ff) << m_ff) + WB'(hdr_ff);
            goff_in = off_w[OffsetBits-1:0];
         end
         bma_pkg::S_F_CHECK: begin
         end
         bma_pkg::S_F_MARK: begin
            if (!mark_q_ff) st_in = bma_pkg::ST_BAD_FREE;
            else begin
               k_in = (ord_q_ff > lv_ff) ? lv_ff : ord_q_ff;
               d_in = 5'(lv_ff - ((ord_q_ff > lv_ff) ? lv_ff : ord_q_ff));
               pos_in = (MaxLevels+1)'(b_ff >> ((ord_q_ff > lv_ff) ? lv_ff : ord_q_ff));
               mark_we = 1'b1;
               mark_wd = 1'b0;
            end
         end
         bma_pkg::S_F_READ: begin
            tree_we = 1'b1;
            tree_wa = slot(d_ff, pos_ff);
            tree_wd = 1'b1;
            tree_rd_en = 1'b1;
            tree_rd_addr = slot(d_ff, pos_ff ^ (MaxLevels+1)'(1));
         end
         bma_pkg::S_F_MERGE: begin
            if (tree_q_ff) begin
               tree_we = 1'b1;
               tree_wa = slot(d_ff, pos_ff);
               tree_wd = 1'b0;
               tree_we2 = 1'b1;
               tree_wa2 = slot(d_ff, pos_ff ^ (MaxLevels+1)'(1));
               d_in = d_ff - 5'd1;
               pos_in = pos_ff >> 1;
               k_in = k_ff + 4'd1;
               mg_in = 1'b1;
            end
         end
         bma_pkg::S_RESULT: begin
            if (!rvalid_ff || rsp.ready) begin
               rvalid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   logic [1:0] ost_ff;
   logic [OffsetBits-1:0] ooff_ff;
   logic [3:0] oord_ff;
   logic omg_ff;
   always_ff @(posedge clock) begin
      if (state_ff == bma_pkg::S_RESULT && (!rvalid_ff || rsp.ready)) begin
         ost_ff <= st_ff;
         ooff_ff <= (st_ff == bma_pkg::ST_OK) ? goff_ff : '0;
         oord_ff <= (st_ff == bma_pkg::ST_OK) ? k_ff : 4'd0;
         omg_ff <= (st_ff == bma_pkg::ST_OK) && mg_ff;
      end
   end

   assign rsp.valid = rvalid_ff;
   assign rsp.status = ost_ff;
   assign rsp.granted_offset = ooff_ff;
   assign rsp.granted_order = oord_ff;
   assign rsp.merged = omg_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == bma_pkg::S_IDLE)
      else $error("request taken outside idle");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      acc |=> !$rose(rvalid_ff))
      else $error("response raised right after accept");
   a_merge_ok: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.merged |-> rsp.status == bma_pkg::ST_OK)
      else $error("merge flagged on failed item");
endmodule

// File: verif/bma_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy allocator checker
// Follows the configuration port and the request channel. It keeps its own
// copy of the free tree, the block orders and the allocation marks, and
// computes the response of every accepted request. Every response beat is
// compared field by field with the oldest computed response.
// ----------------------------------------------------------------------------
module bma_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data,
   bma_req_if         req,
   bma_rsp_if         rsp,
   output int         error_count,
   output int         outstanding
);

   typedef struct {
      bma_pkg::status_type status;
      logic [25:0]         offset;
      logic [3:0]          order;
      logic                merged;
   } grant_type;

   bit          free_tree [2048];
   logic [3:0]  block_order [1024];
   bit          alloc_mark [1024];
   int unsigned min_log2;
   int unsigned levels;
   int unsigned header;
   grant_type   pending_grants [$];
   int          errors;

   function automatic int slot(int unsigned d, longint unsigned p);
      return int'(((64'd1 << d) + p) & 64'd2047);
   endfunction

   function automatic void pool_clear();
      foreach (free_tree[i]) free_tree[i] = 1'b0;
      foreach (alloc_mark[i]) begin
         alloc_mark[i] = 1'b0;
         block_order[i] = 4'd0;
      end
      free_tree[slot(0, 0)] = 1'b1;
   endfunction

   function automatic grant_type allocate_block(longint unsigned req_bytes);
      grant_type       g;
      longint unsigned need, pos, b, off;
      int unsigned     k, d, lvl;
      bit              found;
      g.status = bma_pkg::ST_OK;
      g.offset = '0;
      g.order  = '0;
      g.merged = 1'b0;
      need = req_bytes + header;
      k = 0;
      while (k <= levels && (64'd1 << (min_log2 + k)) < need) k++;
      if (k > levels) begin
         g.status = bma_pkg::ST_TOO_BIG;
         return g;
      end
      d = levels - k;
      lvl = d;
      found = 1'b0;
      pos = 0;
      forever begin
         for (longint unsigned p = 0; p < (64'd1 << lvl); p++) begin
            if (free_tree[slot(lvl, p)]) begin
               pos = p;
               found = 1'b1;
               break;
            end
         end
         if (found || lvl == 0) break;
         lvl--;
      end
      if (!found) begin
         g.status = bma_pkg::ST_NO_BLOCK;
         return g;
      end
      free_tree[slot(lvl, pos)] = 1'b0;
      while (lvl < d) begin
         lvl++;
         pos = pos << 1;
         free_tree[slot(lvl, pos | 64'd1)] = 1'b1;
         free_tree[slot(lvl, pos)] = 1'b0;
      end
      b = pos << k;
      off = b << min_log2;
      alloc_mark[b & 64'd1023] = 1'b1;
      block_order[b & 64'd1023] = 4'(k);
      g.offset = 26'(off + header);
      g.order  = 4'(k);
      return g;
   endfunction

   function automatic grant_type release_block(longint unsigned poff);
      grant_type       g;
      longint unsigned off, b, pos;
      int unsigned     k, d;
      g.status = bma_pkg::ST_BAD_FREE;
      g.offset = '0;
      g.order  = '0;
      g.merged = 1'b0;
      if (poff < header) return g;
      off = poff - header;
      if (off >= (64'd1 << (min_log2 + levels))) return g;
      if ((off & ((64'd1 << min_log2) - 1)) != 0) return g;
      b = off >> min_log2;
      if (!alloc_mark[b & 64'd1023]) return g;
      k = block_order[b & 64'd1023];
      if (k > levels) k = levels;
      alloc_mark[b & 64'd1023] = 1'b0;
      d = levels - k;
      pos = b >> k;
      free_tree[slot(d, pos)] = 1'b1;
      while (d > 0 && free_tree[slot(d, pos ^ 64'd1)]) begin
         free_tree[slot(d, pos)] = 1'b0;
         free_tree[slot(d, pos ^ 64'd1)] = 1'b0;
         d--;
         pos = pos >> 1;
         k++;
         free_tree[slot(d, pos)] = 1'b1;
         g.merged = 1'b1;
      end
      g.status = bma_pkg::ST_OK;
      g.order  = 4'(k);
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type exp_g;
      if (reset) begin
         min_log2 = bma_pkg::MinLog2Reset;
         levels = bma_pkg::LevelsReset;
         header = bma_pkg::HeaderReset;
         pool_clear();
         pending_grants.delete();
         errors = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               bma_pkg::CSR_MIN_LOG2: begin
                  min_log2 = csr_data[4:0] < 3 ? 3 :
                             (csr_data[4:0] > 16 ? 16 : csr_data[4:0]);
                  pool_clear();
               end
               bma_pkg::CSR_LEVELS: begin
                  levels = csr_data[3:0] > 10 ? 10 : csr_data[3:0];
                  pool_clear();
               end
               bma_pkg::CSR_HEADER: begin
                  header = csr_data > 64 ? 64 : csr_data;
                  pool_clear();
               end
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (req.op == bma_pkg::OP_ALLOC)
               pending_grants.insert(pending_grants.size(),
                                     allocate_block(req.request_bytes));
            else
               pending_grants.insert(pending_grants.size(),
                                     release_block(req.payload_offset));
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_grants.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: response beat with none expected at %0t", $realtime);
            end else begin
               exp_g = pending_grants.pop_front();
               if (rsp.status !== exp_g.status || rsp.granted_offset !== exp_g.offset ||
                   rsp.granted_order !== exp_g.order || rsp.merged !== exp_g.merged) begin
                  errors++;
                  if (errors <= 10)
                     $display({"ERROR: at %0t expected st=%0d off=%0d ord=%0d mg=%0d,",
                               " got st=%0d off=%0d ord=%0d mg=%0d"},
                              $realtime, exp_g.status, exp_g.offset, exp_g.order,
                              exp_g.merged, rsp.status, rsp.granted_offset,
                              rsp.granted_order, rsp.merged);
               end
            end
         end
      end
      error_count <= errors;
      outstanding <= pending_grants.size();
   end

endmodule

// File: verif/tb_buddy_memory_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy allocator testbench
// Drives allocation and free requests through a series of pool settings:
// a short directed set, then random traffic built mostly from frees of live
// blocks and sized allocations, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_buddy_memory_allocator;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = bma_pkg::CSR_MIN_LOG2;
   logic [6:0] csr_data = '0;
   int         error_count;
   int         outstanding;
   int         stall_left;
   longint     cycles = 0;
   bit         quiet;
   int unsigned cur_m, cur_l, cur_h;
   logic       issued_ops [$];
   logic [25:0] live_blocks [$];

   bma_req_if req_ch ();
   bma_rsp_if rsp_ch ();

   buddy_memory_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   bma_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.op <= bma_pkg::OP_ALLOC;
      req_ch.request_bytes <= '0;
      req_ch.payload_offset <= '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd30000000) begin
         $display("tb_buddy_memory_allocator: FAIL");
         $finish;
      end
   end

   // Response side: random stall after each beat, and collection of live blocks.
   always @(posedge clock) begin
      int gap;
      logic op_was;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         gap = quiet ? 0 : $urandom_range(0, 13);
         stall_left <= gap;
         rsp_ch.ready <= (gap == 0);
         op_was = issued_ops.pop_front();
         if (op_was == bma_pkg::OP_ALLOC && rsp_ch.status == bma_pkg::ST_OK)
            live_blocks.insert(live_blocks.size(), rsp_ch.granted_offset);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_item(logic op, logic [25:0] rq, logic [25:0] po);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.request_bytes <= rq;
      req_ch.payload_offset <= po;
      do @(posedge clock); while (!req_ch.ready);
      issued_ops.insert(issued_ops.size(), op);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(bma_pkg::csr_index_type idx, logic [6:0] value);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(logic [6:0] m, logic [6:0] l, logic [6:0] h);
      write_reg(bma_pkg::CSR_MIN_LOG2, m);
      write_reg(bma_pkg::CSR_LEVELS, l);
      write_reg(bma_pkg::CSR_HEADER, h);
      cur_m = m[4:0] < 3 ? 3 : (m[4:0] > 16 ? 16 : m[4:0]);
      cur_l = l[3:0] > 10 ? 10 : l[3:0];
      cur_h = h > 64 ? 64 : h;
      live_blocks.delete();
   endtask

   task automatic random_item();
      int          pick, idx;
      longint      size, x;
      logic [25:0] po;
      pick = $urandom_range(0, 99);
      if (pick < 45 || (pick >= 50 && pick < 85 && live_blocks.size() == 0)) begin
         size = 64'd1 << (cur_m + $urandom_range(0, cur_l));
         x = size - $urandom_range(0, int'(size / 2));
         send_item(bma_pkg::OP_ALLOC, 26'(x > cur_h ? x - cur_h : 0), 26'($urandom));
      end else if (pick < 50) begin
         send_item(bma_pkg::OP_ALLOC,
                   $urandom_range(0, 1) ? 26'($urandom) : 26'($urandom_range(0, 300)),
                   26'($urandom));
      end else if (pick < 85) begin
         idx = $urandom_range(0, live_blocks.size() - 1);
         po = live_blocks[idx];
         live_blocks.delete(idx);
         send_item(bma_pkg::OP_FREE, 26'($urandom), po);
      end else begin
         case ($urandom_range(0, 3))
            0: po = 26'($urandom);
            1: po = live_blocks.size() ? live_blocks[0] + 26'($urandom_range(1, 200)) : 26'd0;
            2: po = 26'($urandom_range(0, 64));
            default: po = 26'(((64'd1 << cur_m) * $urandom_range(0, 1 << cur_l)) + cur_h);
         endcase
         send_item(bma_pkg::OP_FREE, 26'($urandom), po);
      end
   endtask

   initial begin
      quiet = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      cur_m = bma_pkg::MinLog2Reset;
      cur_l = bma_pkg::LevelsReset;
      cur_h = bma_pkg::HeaderReset;

      send_item(bma_pkg::OP_ALLOC, 26'd0, 26'd0);
      send_item(bma_pkg::OP_ALLOC, 26'h3FFFFFF, 26'h3FFFFFF);
      send_item(bma_pkg::OP_ALLOC, 26'd112, 26'd0);
      send_item(bma_pkg::OP_ALLOC, 26'd113, 26'd0);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd0);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd17);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd144);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'h3FFFFFF);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd16 + 26'd131072);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd16);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd16);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd272);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd400);
      send_item(bma_pkg::OP_ALLOC, 26'd131072 - 26'd16, 26'd0);
      send_item(bma_pkg::OP_ALLOC, 26'd0, 26'd0);
      send_item(bma_pkg::OP_FREE, 26'd0, 26'd16);
      drain();
      for (int i = 0; i < 30; i++) random_item();

      for (int phase = 0; phase < 22; phase++) begin
         quiet = (phase % 5 == 2);
         case (phase)
            0: configure(7'd3, 7'd0, 7'd0);
            1: configure(7'd127, 7'd127, 7'd127);
            2: configure(7'd0, 7'd4, 7'd1);
            3: configure(7'd16, 7'd10, 7'd64);
            default: configure(7'($urandom_range(0, 127)), 7'($urandom_range(0, 6)),
                               7'($urandom_range(0, 127)));
         endcase
         for (int i = 0; i < (phase == 1 || phase == 3 ? 40 : 70); i++) begin
            random_item();
            if (phase == 5 && i == 35) drain();
         end
      end

      drain();
      if (error_count == 0)
         $display("tb_buddy_memory_allocator: PASS");
      else
         $display("tb_buddy_memory_allocator: FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/bma_pkg.sv
rtl/bma_if.sv
rtl/buddy_memory_allocator.sv
verif/bma_checker.sv
verif/tb_buddy_memory_allocator.sv
